[hw/rtl/adsr_eg_pkg.sv]
// ----------------------------------------------------------------------------
// adsr_eg_pkg
// Types and constants shared by the ADSR envelope generator modules.
// ----------------------------------------------------------------------------
package adsr_eg_pkg;

  localparam int unsigned LEVEL_W = 24;
  localparam int unsigned COEF_W  = 24;
  localparam int unsigned OUT_W   = 23;

  localparam logic signed [LEVEL_W-1:0] ONE_Q22       = 24'sd4194304;
  localparam logic signed [LEVEL_W-1:0] HALF_Q22      = 24'sd2097152;
  localparam logic signed [LEVEL_W-1:0] RELEASE_FLOOR = 24'sd419;
  localparam logic [OUT_W-1:0]          ONE_Q22_U     = 23'd4194304;

  typedef enum logic [2:0] {
    STAGE_IDLE    = 3'd0,
    STAGE_ATTACK  = 3'd1,
    STAGE_DECAY   = 3'd2,
    STAGE_SUSTAIN = 3'd3,
    STAGE_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    REG_ATTACK_COEF  = 3'd0,
    REG_ATTACK_BASE  = 3'd1,
    REG_DECAY_COEF   = 3'd2,
    REG_DECAY_BASE   = 3'd3,
    REG_SUSTAIN      = 3'd4,
    REG_RELEASE_COEF = 3'd5,
    REG_RELEASE_BASE = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic signed [23:0] gate_sample;
    logic               last_in_block;
  } in_item_t;

  typedef struct packed {
    logic [22:0] envelope_level;
    logic [2:0]  envelope_stage;
    logic        block_end;
  } out_item_t;

  typedef struct packed {
    logic [COEF_W-1:0]         attack_coef;
    logic signed [LEVEL_W-1:0] attack_base;
    logic [COEF_W-1:0]         decay_coef;
    logic signed [LEVEL_W-1:0] decay_base;
    logic [OUT_W-1:0]          sustain_level;
    logic [COEF_W-1:0]         release_coef;
    logic signed [LEVEL_W-1:0] release_base;
  } cfg_t;

endpackage

[hw/rtl/adsr_eg_cfg.sv]
// ----------------------------------------------------------------------------
// adsr_eg_cfg
// Configuration register file: seven write-only registers.
// ----------------------------------------------------------------------------
module adsr_eg_cfg
  import adsr_eg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t             cfg_r;
  logic [OUT_W-1:0] sustain_wr;

  // clamp sustain to 1.0 on write
  always_comb begin
    sustain_wr = cfg_wdata[OUT_W-1:0];
    if (sustain_wr > ONE_Q22_U) begin
      sustain_wr = ONE_Q22_U;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coef   <= '0;
      cfg_r.attack_base   <= ONE_Q22;
      cfg_r.decay_coef    <= '0;
      cfg_r.decay_base    <= '0;
      cfg_r.sustain_level <= ONE_Q22_U;
      cfg_r.release_coef  <= '0;
      cfg_r.release_base  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK_COEF:  cfg_r.attack_coef   <= cfg_wdata;
        REG_ATTACK_BASE:  cfg_r.attack_base   <= signed'(cfg_wdata);
        REG_DECAY_COEF:   cfg_r.decay_coef    <= cfg_wdata;
        REG_DECAY_BASE:   cfg_r.decay_base    <= signed'(cfg_wdata);
        REG_SUSTAIN:      cfg_r.sustain_level <= sustain_wr;
        REG_RELEASE_COEF: cfg_r.release_coef  <= cfg_wdata;
        REG_RELEASE_BASE: cfg_r.release_base  <= signed'(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/adsr_eg_one_pole.sv]
// ----------------------------------------------------------------------------
// adsr_eg_one_pole
// One-pole update: base + level * coef, floor rounded, saturated to 24 bits.
// ----------------------------------------------------------------------------
module adsr_eg_one_pole
  import adsr_eg_pkg::*;
(
  input  logic signed [LEVEL_W-1:0] base,
  input  logic signed [LEVEL_W-1:0] level,
  input  logic [COEF_W-1:0]         coef,
  output logic signed [LEVEL_W-1:0] result
);

  logic signed [LEVEL_W+COEF_W:0]   prod;
  logic signed [LEVEL_W:0]          prod_q;
  logic signed [LEVEL_W+1:0]        sum;

  // Q2.22 x Q0.24 -> Q2.46; arithmetic shift floors toward minus infinity
  assign prod   = level * signed'({1'b0, coef});
  assign prod_q = prod[LEVEL_W+COEF_W:COEF_W];
  assign sum    = {{2{base[LEVEL_W-1]}}, base} + {prod_q[LEVEL_W], prod_q};

  always_comb begin
    if (sum > 26'sd8388607) begin
      result = 24'sd8388607;
    end else if (sum < -26'sd8388608) begin
      result = -24'sd8388608;
    end else begin
      result = sum[LEVEL_W-1:0];
    end
  end

endmodule

[hw/rtl/adsr_eg_core.sv]
// ----------------------------------------------------------------------------
// adsr_eg_core
// Stage state machine, level register and result register.
// ----------------------------------------------------------------------------
module adsr_eg_core
  import adsr_eg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      req_valid,
  input  in_item_t  req_data,
  output logic      core_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  stage_t                    stage_r, stage_nxt, stage_entry;
  logic signed [LEVEL_W-1:0] level_r, level_nxt;
  logic                      gate_was_r;
  logic                      out_valid_r;
  out_item_t                 out_data_r;
  logic                      gate_high;
  logic                      take;
  logic signed [LEVEL_W-1:0] pole_base;
  logic [COEF_W-1:0]         pole_coef;
  logic signed [LEVEL_W-1:0] pole_res;
  logic signed [LEVEL_W-1:0] sustain_s;
  logic [OUT_W-1:0]          shown;

  assign core_ready = !out_valid_r || !out_stall;
  assign take       = req_valid && core_ready;
  assign gate_high  = req_data.gate_sample > HALF_Q22;
  assign sustain_s  = signed'({1'b0, cfg.sustain_level});

  // gate edges pick the stage the update runs in
  always_comb begin
    stage_entry = stage_r;
    if (gate_high && !gate_was_r) begin
      stage_entry = STAGE_ATTACK;
    end else if (!gate_high && gate_was_r && stage_r != STAGE_IDLE) begin
      stage_entry = STAGE_RELEASE;
    end
  end

  always_comb begin
    case (stage_entry)
      STAGE_ATTACK: begin
        pole_base = cfg.attack_base;
        pole_coef = cfg.attack_coef;
      end
      STAGE_DECAY: begin
        pole_base = cfg.decay_base;
        pole_coef = cfg.decay_coef;
      end
      default: begin
        pole_base = cfg.release_base;
        pole_coef = cfg.release_coef;
      end
    endcase
  end

  adsr_eg_one_pole u_one_pole (
    .base   (pole_base),
    .level  (level_r),
    .coef   (pole_coef),
    .result (pole_res)
  );

  // next stage
  always_comb begin
    case (stage_entry)
      STAGE_ATTACK:  stage_nxt = (pole_res >= ONE_Q22) ? STAGE_DECAY : STAGE_ATTACK;
      STAGE_DECAY:   stage_nxt = (pole_res <= sustain_s) ? STAGE_SUSTAIN : STAGE_DECAY;
      STAGE_SUSTAIN: stage_nxt = STAGE_SUSTAIN;
      STAGE_RELEASE: stage_nxt = (pole_res <= RELEASE_FLOOR) ? STAGE_IDLE : STAGE_RELEASE;
      default:       stage_nxt = STAGE_IDLE;
    endcase
  end

  // next level
  always_comb begin
    case (stage_entry)
      STAGE_ATTACK:  level_nxt = (pole_res >= ONE_Q22) ? ONE_Q22 : pole_res;
      STAGE_DECAY:   level_nxt = (pole_res <= sustain_s) ? sustain_s : pole_res;
      STAGE_SUSTAIN: level_nxt = sustain_s;
      STAGE_RELEASE: level_nxt = (pole_res <= RELEASE_FLOOR) ? '0 : pole_res;
      default:       level_nxt = '0;
    endcase
  end

  // clamp the shown level to 0..1.0; the state keeps the raw value
  always_comb begin
    if (level_nxt[LEVEL_W-1]) begin
      shown = '0;
    end else if (level_nxt > ONE_Q22) begin
      shown = ONE_Q22_U;
    end else begin
      shown = level_nxt[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= STAGE_IDLE;
      level_r     <= '0;
      gate_was_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (core_ready) begin
        out_valid_r <= req_valid;
      end
      if (take) begin
        stage_r    <= stage_nxt;
        level_r    <= level_nxt;
        gate_was_r <= gate_high;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.envelope_level <= shown;
      out_data_r.envelope_stage <= stage_nxt;
      out_data_r.block_end      <= req_data.last_in_block;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.envelope_level <= ONE_Q22_U)
    else $error("envelope level above 1.0");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.envelope_stage == STAGE_IDLE) |->
      out_data_r.envelope_level == '0)
    else $error("idle stage with nonzero level");

  a_attack_below_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.envelope_stage == STAGE_ATTACK) |->
      out_data_r.envelope_level < ONE_Q22_U)
    else $error("attack shown at or above 1.0");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(stage_r) && $stable(level_r)))
    else $error("envelope state advanced under stall");
`endif

endmodule

[hw/rtl/adsr_envelope_generator_unit.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// Exponential one-pole ADSR envelope generator, one gate sample per request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | in_data  (gate_sample, last_in_block)
//  out_    | output    | out_valid/out_stall | out_data (level, stage, block_end)
//  cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
//  One request per cycle unless out_stall holds it; a request passes the input register, then the result register.
//  The level feedback (multiply, add, saturate, threshold) closes through level_r alone.
//  rst_n is synchronous; it clears state to idle, level zero, and reloads registers.
//  out_stall holds the result register; the input register then fills and
//  raises in_stall.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit
  import adsr_eg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  cfg_t     cfg;
  logic     s1_valid_r;
  in_item_t s1_data_r;
  logic     core_ready;

  adsr_eg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register
  assign in_stall = s1_valid_r && !core_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  adsr_eg_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .req_valid  (s1_valid_r),
    .req_data   (s1_data_r),
    .core_ready (core_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

[bench/adsr_envelope_checker.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_checker
// Watches the gate and envelope channels and the register port of the ADSR
// envelope generator. It keeps its own envelope state and register copy,
// predicts one envelope sample per accepted gate request, and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module adsr_envelope_checker
  import adsr_eg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  output int          pending,
  output int          errors,
  output int          results,
  output logic [4:0]  stages_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                      regs;
  stage_t                    stage_q;
  logic signed [LEVEL_W-1:0] level_q;
  logic                      gate_q;
  out_item_t                 envelope_q[$];

  // level * coef is Q2.46; the arithmetic shift floors it back to Q2.22
  function automatic logic signed [LEVEL_W-1:0] one_pole_step(
    logic signed [LEVEL_W-1:0] base,
    logic signed [LEVEL_W-1:0] lvl,
    logic [COEF_W-1:0]         coef
  );
    longint prod;
    longint sum;
    prod = longint'(lvl) * longint'(coef);
    sum  = longint'(base) + (prod >>> 24);
    if (sum > 64'sd8388607) sum = 64'sd8388607;
    if (sum < -64'sd8388608) sum = -64'sd8388608;
    return sum[LEVEL_W-1:0];
  endfunction

  function automatic void apply_write(logic [2:0] idx, logic [23:0] val);
    case (idx)
      REG_ATTACK_COEF:  regs.attack_coef  = val;
      REG_ATTACK_BASE:  regs.attack_base  = val;
      REG_DECAY_COEF:   regs.decay_coef   = val;
      REG_DECAY_BASE:   regs.decay_base   = val;
      REG_SUSTAIN:      regs.sustain_level = (val[22:0] > ONE_Q22_U) ? ONE_Q22_U : val[22:0];
      REG_RELEASE_COEF: regs.release_coef = val;
      REG_RELEASE_BASE: regs.release_base = val;
      default: ;  // unmapped index: drop the write
    endcase
  endfunction

  function automatic out_item_t envelope_step(in_item_t req);
    logic      gate_hi;
    out_item_t res;
    gate_hi = req.gate_sample > HALF_Q22;
    if (gate_hi && !gate_q) begin
      stage_q = STAGE_ATTACK;
    end else if (!gate_hi && gate_q && stage_q != STAGE_IDLE) begin
      stage_q = STAGE_RELEASE;
    end
    gate_q = gate_hi;

    case (stage_q)
      STAGE_ATTACK: begin
        level_q = one_pole_step(regs.attack_base, level_q, regs.attack_coef);
        if (level_q >= ONE_Q22) begin
          level_q = ONE_Q22;
          stage_q = STAGE_DECAY;
        end
      end
      STAGE_DECAY: begin
        level_q = one_pole_step(regs.decay_base, level_q, regs.decay_coef);
        if (int'(level_q) <= int'(regs.sustain_level)) begin
          level_q = {1'b0, regs.sustain_level};
          stage_q = STAGE_SUSTAIN;
        end
      end
      STAGE_SUSTAIN: level_q = {1'b0, regs.sustain_level};
      STAGE_RELEASE: begin
        level_q = one_pole_step(regs.release_base, level_q, regs.release_coef);
        if (level_q <= RELEASE_FLOOR) begin
          level_q = '0;
          stage_q = STAGE_IDLE;
        end
      end
      default: begin
        stage_q = STAGE_IDLE;
        level_q = '0;
      end
    endcase

    // the kept level may leave 0..1.0; only the shown level is clamped
    if (level_q < 0) begin
      res.envelope_level = '0;
    end else if (level_q > ONE_Q22) begin
      res.envelope_level = ONE_Q22_U;
    end else begin
      res.envelope_level = level_q[OUT_W-1:0];
    end
    res.envelope_stage = stage_q;
    res.block_end      = req.last_in_block;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs.attack_coef   = '0;
      regs.attack_base   = ONE_Q22;
      regs.decay_coef    = '0;
      regs.decay_base    = '0;
      regs.sustain_level = ONE_Q22_U;
      regs.release_coef  = '0;
      regs.release_base  = '0;
      stage_q            = STAGE_IDLE;
      level_q            = '0;
      gate_q             = 1'b0;
      stages_seen        = '0;
      envelope_q.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) envelope_q.push_back(envelope_step(in_data));
      if (out_valid && !out_stall) begin
        if (envelope_q.size() == 0) begin
          errors++;
          $display("%0t: envelope result with no request pending: level %0d stage %0d end %0b",
                   $time, out_data.envelope_level, out_data.envelope_stage, out_data.block_end);
        end else begin
          want = envelope_q.pop_front();
          results++;
          if (want.envelope_stage <= STAGE_RELEASE) stages_seen[want.envelope_stage] = 1'b1;
          if (out_data.envelope_level !== want.envelope_level) begin
            errors++;
            $display("%0t: envelope_level expected %0d, got %0d",
                     $time, want.envelope_level, out_data.envelope_level);
          end
          if (out_data.envelope_stage !== want.envelope_stage) begin
            errors++;
            $display("%0t: envelope_stage expected %0d, got %0d",
                     $time, want.envelope_stage, out_data.envelope_stage);
          end
          if (out_data.block_end !== want.block_end) begin
            errors++;
            $display("%0t: block_end expected %0b, got %0b",
                     $time, want.block_end, out_data.block_end);
          end
        end
      end
    end
    pending <= envelope_q.size();
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the ADSR envelope generator: a short directed run over the
// gate thresholds and stage changes, then gate notes with random content
// under several register settings, extremes included, with bursty requests,
// random output stalls and long output hold-offs. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adsr_eg_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 122;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum int {GATE_ANY, GATE_HIGH, GATE_LOW} gate_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_wdata;

  int          pending;
  int          errors;
  int          results;
  logic [4:0]  stages_seen;

  int          cycle_count = 0;
  int          burst_left  = 0;
  int          samples_sent = 0;
  int          settings    = 1;
  int          hold_asks   = 0;
  int          holds_done  = 0;

  adsr_envelope_generator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  adsr_envelope_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .errors      (errors),
    .results     (results),
    .stages_seen (stages_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** adsr_envelope_generator_unit: FAILED **");
      $finish;
    end
  end

  // Output side: stall segments of random density; a long hold-off on request.
  initial begin
    int span;
    int pct;
    out_stall <= 1'b0;
    forever begin
      if (holds_done < hold_asks) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span = $urandom_range(20, 120);
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 50;
          default: pct = 85;
        endcase
        repeat (span) begin
          out_stall <= ($urandom_range(99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  function automatic in_item_t gate_item(gate_kind_t kind);
    in_item_t req;
    case (kind)
      GATE_HIGH: req.gate_sample = 24'($urandom_range(2097153, 8388607));
      GATE_LOW:  req.gate_sample = 24'(int'($urandom_range(0, 10485760)) - 8388608);
      default:   req.gate_sample = 24'($urandom());
    endcase
    req.last_in_block = 1'($urandom_range(1));
    return req;
  endfunction

  // Offer one request in bursts; drop valid only for a gap between bursts.
  task automatic push_gate(in_item_t req);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    burst_left--;
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c, logic [23:0] sustain_word);
    wait_idle();
    write_reg(REG_ATTACK_COEF, c.attack_coef);
    write_reg(REG_ATTACK_BASE, c.attack_base);
    write_reg(REG_DECAY_COEF, c.decay_coef);
    write_reg(REG_DECAY_BASE, c.decay_base);
    write_reg(REG_SUSTAIN, sustain_word);
    write_reg(REG_RELEASE_COEF, c.release_coef);
    write_reg(REG_RELEASE_BASE, c.release_base);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Attack settles above 1.0, decay below sustain, release toward zero,
  // so that notes walk through every stage.
  task automatic shaped_config(output cfg_t c, output logic [23:0] sustain_word);
    int unsigned ac;
    int unsigned dc;
    int unsigned rc;
    int          sus;
    ac  = $urandom_range(4000000, 15000000);
    dc  = $urandom_range(4000000, 15000000);
    rc  = $urandom_range(4000000, 14000000);
    sus = $urandom_range(0, 4194304);
    c.attack_coef   = 24'(ac);
    c.attack_base   = 24'(((longint'(16777216 - ac) * 64'sd4613734) >>> 24)
                          + longint'($urandom_range(1, 40000)));
    c.decay_coef    = 24'(dc);
    c.decay_base    = 24'((longint'(16777216 - dc) *
                           longint'(sus - int'($urandom_range(1000, 400000)))) >>> 24);
    c.sustain_level = 23'(sus);
    c.release_coef  = 24'(rc);
    c.release_base  = 24'(-int'($urandom_range(0, 30000)));
    sustain_word    = 24'(sus);
  endtask

  initial begin
    static int   dir_gate[22] = '{-8388608, 2097152, 2097153, 8388607, 8388607, 0, -1,
                                  8388607, -8388608, 8388607, 4194304, 3000000,
                                  2500000, 6000000, 7000000, 8000000, 2097152,
                                  -4194304, 100, 2097153, 5000000, 8388607};
    cfg_t        c;
    logic [23:0] sustain_word;
    in_item_t    req;
    int          seg_left;
    logic        note_high;
    logic [191:0] rnd_word;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: attack jumps to 1.0, decay and release finish at once
    for (int k = 0; k < 22; k++) begin
      if (k == 8) begin
        c.attack_coef   = 24'd15099494;
        c.attack_base   = 24'sd629146;
        c.decay_coef    = 24'd15099494;
        c.decay_base    = 24'sd209715;
        c.sustain_level = 23'd2516582;
        c.release_coef  = 24'd8388608;
        c.release_base  = '0;
        load_config(c, {1'b0, c.sustain_level});
      end
      req.gate_sample   = 24'(dir_gate[k]);
      req.last_in_block = k[0];
      push_gate(req);
    end

    seg_left  = 0;
    note_high = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: begin
          c.attack_coef  = '1;
          c.attack_base  = 24'sh7FFFFF;
          c.decay_coef   = '1;
          c.decay_base   = 24'sh7FFFFF;
          c.release_coef = '1;
          c.release_base = 24'sh7FFFFF;
          load_config(c, 24'hFFFFFF);
        end
        3: begin
          c.attack_coef  = '0;
          c.attack_base  = 24'sh800000;
          c.decay_coef   = '0;
          c.decay_base   = 24'sh800000;
          c.release_coef = '0;
          c.release_base = 24'sh800000;
          load_config(c, 24'h800000);
        end
        4: begin
          rnd_word = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom()};
          c = rnd_word[$bits(cfg_t)-1:0];
          load_config(c, 24'($urandom()));
          write_reg(REG_UNMAPPED, 24'($urandom()));
          cfg_we <= 1'b0;
        end
        default: begin
          shaped_config(c, sustain_word);
          load_config(c, sustain_word);
          hold_asks++;
        end
      endcase

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (seg_left == 0) begin
          note_high = !note_high;
          seg_left  = note_high ? $urandom_range(1, 60) : $urandom_range(1, 90);
        end
        seg_left--;
        if ($urandom_range(9) == 0) begin
          req = gate_item(GATE_ANY);
        end else begin
          req = gate_item(note_high ? GATE_HIGH : GATE_LOW);
        end
        push_gate(req);
      end
    end

    wait_idle();

    $display("Run covered %0d gate samples under %0d register settings, %0d results compared.",
             samples_sent, settings, results);
    $display("Stages reached (bit per stage) %b; output held off %0d times for %0d cycles.",
             stages_seen, holds_done, HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("** adsr_envelope_generator_unit: PASSED **");
    end else begin
      $display("** adsr_envelope_generator_unit: FAILED **");
    end
    $finish;
  end

endmodule
